// File: rtl/core/atcm_pkg.sv
// Shared constants and types for the AT command line matcher.
// No dependencies; included first by every file of the block.
`timescale 1ns / 1ps
`default_nettype none

package atcm_pkg;

  // Default sizes of the line buffer and of the command table
  localparam int LINE_DEPTH_DEF    = 40;
  localparam int TABLE_ENTRIES_DEF = 32;

  // Input transaction codes
  typedef enum logic [1:0] {
    CMD_RX_BYTE   = 2'd0,
    CMD_LOAD_CHAR = 2'd1,
    CMD_LOAD_LEN  = 2'd2,
    CMD_EXIT      = 2'd3
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TX_BYTE    = 2'd0,
    KIND_MATCH      = 2'd1,
    KIND_EMPTY_LINE = 2'd2,
    KIND_ARG_BYTE   = 2'd3
  } kind_t;

  // Escape tracker: pluses counted in data mode, then command mode
  typedef enum logic [1:0] {
    ESC_NONE     = 2'd0,
    ESC_ONE      = 2'd1,
    ESC_TWO      = 2'd2,
    ESC_CMD_MODE = 2'd3
  } esc_t;

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] NULL_CMD = 8'hFF;

  // Reply sent on entering command mode: O, K, LF, CR
  function automatic logic [7:0] ok_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_O;
      2'd1:    ch = CH_K;
      2'd2:    ch = CH_LF;
      default: ch = CH_CR;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/at_command_line_matcher.sv
// AT command line matcher: escape detection, line capture and table search.
// Depends on atcm_pkg for codes, characters and default sizes.
//
// Usage: bytes and table loads arrive on the in_ channel (valid/ready); the
// results leave on the out_ channel (valid/ready) through one output
// register. cfg_write_en/cfg_write_data set the number of table entries
// searched. A transaction that gives no result leaves the sequencer idle.
// The third plus of the escape gives O, K, LF, CR, one per cycle while the
// output register is free. On CR or LF after "AT" and a non-empty line a
// shared compare path walks the table: it reads each entry's length, then
// reads and compares its characters, then gives one result for the match
// and reads and sends each argument byte. in_ready is high only while the
// sequencer is idle, so one transaction is handled at a time; a new one is
// taken while the last result still waits in the output register. When a
// result waits and out_ready is low, the emitting states hold until the
// register frees. Synchronous reset returns to data mode with no plus seen,
// clears the line and the entry count; the command table and the line
// buffer are not cleared, and entries must be loaded before they are searched.
`timescale 1ns / 1ps
`default_nettype none

module at_command_line_matcher #(
  parameter int LINE_DEPTH    = atcm_pkg::LINE_DEPTH_DEF,
  parameter int TABLE_ENTRIES = atcm_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_data,
  input  wire logic [4:0] in_table_index,
  input  wire logic [5:0] in_char_position,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_value,
  output logic            out_last,
  output logic            out_command_mode,
  input  wire logic       cfg_write_en,
  input  wire logic [5:0] cfg_write_data
);

  localparam int LW  = $clog2(LINE_DEPTH);
  localparam int LLW = $clog2(LINE_DEPTH + 1);
  localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EC  = $clog2(TABLE_ENTRIES + 1);
  localparam int CD  = TABLE_ENTRIES * LINE_DEPTH;
  localparam int CW  = $clog2(CD);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OK,
    ST_EMPTY,
    ST_LEN,
    ST_LCHK,
    ST_CRD,
    ST_CCHK,
    ST_IDX,
    ST_ARD,
    ST_AEMIT
  } state_t;

  // Control and output registers
  state_t               state_r, state_nxt;
  atcm_pkg::esc_t       esc_r, esc_nxt;
  logic                 seen_a_r, seen_a_nxt;
  logic                 seen_t_r, seen_t_nxt;
  logic [LLW-1:0]       line_len_r, line_len_nxt;
  logic [5:0]           cmd_count_r, cmd_count_nxt;
  logic [EC-1:0]        entry_r, entry_nxt;
  logic [CW-1:0]        base_r, base_nxt;
  logic [LLW-1:0]       pos_r, pos_nxt;
  logic [1:0]           ok_cnt_r, ok_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  atcm_pkg::kind_t      out_kind_r, out_kind_nxt;
  logic [7:0]           out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_mode_r, out_mode_nxt;

  // Memories and their registered read data
  logic [7:0]           line_mem  [LINE_DEPTH];
  logic [7:0]           chars_mem [CD];
  logic [7:0]           len_mem   [TABLE_ENTRIES];
  logic [7:0]           line_q_r;
  logic [7:0]           char_q_r;
  logic [7:0]           len_q_r;

  logic                 line_we, chars_we, len_we;
  logic [CW-1:0]        chars_waddr;
  logic [CW-1:0]        chars_raddr;
  logic [EC-1:0]        limit;
  logic                 accept, slot_free, mode_on;
  atcm_pkg::cmd_t       cmd;

  assign accept      = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  assign mode_on     = (esc_r == atcm_pkg::ESC_CMD_MODE);
  assign cmd         = atcm_pkg::cmd_t'(in_cmd);
  assign chars_waddr = CW'(32'(in_table_index) * 32'(LINE_DEPTH) + 32'(in_char_position));
  assign chars_raddr = base_r + CW'(pos_r);
  assign limit       = (32'(cmd_count_r) > 32'(TABLE_ENTRIES)) ? EC'(TABLE_ENTRIES)
                                                              : EC'(cmd_count_r);

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_last         = out_last_r;
  assign out_command_mode = out_mode_r;

  // Next state of the sequencer and of the output register
  always_comb begin
    state_nxt     = state_r;
    esc_nxt       = esc_r;
    seen_a_nxt    = seen_a_r;
    seen_t_nxt    = seen_t_r;
    line_len_nxt  = line_len_r;
    cmd_count_nxt = cfg_write_en ? cfg_write_data : cmd_count_r;
    entry_nxt     = entry_r;
    base_nxt      = base_r;
    pos_nxt       = pos_r;
    ok_cnt_nxt    = ok_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_mode_nxt  = out_mode_r;
    line_we       = 1'b0;
    chars_we      = 1'b0;
    len_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            atcm_pkg::CMD_LOAD_CHAR: begin
              chars_we = (32'(in_table_index) < 32'(TABLE_ENTRIES)) &&
                         (32'(in_char_position) < 32'(LINE_DEPTH));
            end
            atcm_pkg::CMD_LOAD_LEN: begin
              len_we = (32'(in_table_index) < 32'(TABLE_ENTRIES));
            end
            atcm_pkg::CMD_EXIT: begin
              esc_nxt = atcm_pkg::ESC_NONE;
            end
            default: begin
              if (!mode_on) begin
                // count pluses; anything else restarts the escape
                if (in_data != atcm_pkg::CH_PLUS) begin
                  esc_nxt = atcm_pkg::ESC_NONE;
                end else begin
                  esc_nxt = atcm_pkg::esc_t'(esc_r + 2'd1);
                  if (esc_r == atcm_pkg::ESC_TWO) begin
                    ok_cnt_nxt = 2'd0;
                    state_nxt  = ST_OK;
                  end
                end
              end else if (!seen_a_r) begin
                seen_a_nxt = (in_data == atcm_pkg::CH_A);
              end else if (!seen_t_r) begin
                if (in_data == atcm_pkg::CH_T) begin
                  seen_t_nxt   = 1'b1;
                  line_len_nxt = '0;
                end
              end else if (in_data == atcm_pkg::CH_LF || in_data == atcm_pkg::CH_CR) begin
                if (line_len_r == '0) begin
                  state_nxt = ST_EMPTY;
                end else begin
                  entry_nxt = '0;
                  base_nxt  = '0;
                  state_nxt = ST_LEN;
                end
              end else if (line_len_r < LLW'(LINE_DEPTH)) begin
                line_we      = 1'b1;
                line_len_nxt = line_len_r + LLW'(1);
              end
            end
          endcase
        end
      end

      // Send the command mode reply
      ST_OK: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = atcm_pkg::KIND_TX_BYTE;
          out_value_nxt = atcm_pkg::ok_char(ok_cnt_r);
          out_last_nxt  = (ok_cnt_r == 2'd3);
          out_mode_nxt  = mode_on;
          ok_cnt_nxt    = ok_cnt_r + 2'd1;
          if (ok_cnt_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      // Report the null command and drop the line
      ST_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = atcm_pkg::KIND_EMPTY_LINE;
          out_value_nxt = atcm_pkg::NULL_CMD;
          out_last_nxt  = 1'b1;
          out_mode_nxt  = mode_on;
          seen_a_nxt    = 1'b0;
          seen_t_nxt    = 1'b0;
          line_len_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end

      // Fetch the next entry's length, or end the search without a match
      ST_LEN: begin
        if (entry_r >= limit) begin
          seen_a_nxt   = 1'b0;
          seen_t_nxt   = 1'b0;
          line_len_nxt = '0;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_LCHK;
        end
      end

      ST_LCHK: begin
        if (len_q_r != 8'd0 && len_q_r <= 8'(line_len_r)) begin
          pos_nxt   = '0;
          state_nxt = ST_CRD;
        end else begin
          entry_nxt = entry_r + EC'(1);
          base_nxt  = base_r + CW'(LINE_DEPTH);
          state_nxt = ST_LEN;
        end
      end

      // Wait for both character reads
      ST_CRD: begin
        state_nxt = ST_CCHK;
      end

      ST_CCHK: begin
        if (char_q_r != line_q_r) begin
          entry_nxt = entry_r + EC'(1);
          base_nxt  = base_r + CW'(LINE_DEPTH);
          state_nxt = ST_LEN;
        end else if (8'(pos_r) + 8'd1 == len_q_r) begin
          state_nxt = ST_IDX;
        end else begin
          pos_nxt   = pos_r + LLW'(1);
          state_nxt = ST_CRD;
        end
      end

      // Report the matched entry
      ST_IDX: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = atcm_pkg::KIND_MATCH;
          out_value_nxt = 8'(entry_r);
          out_last_nxt  = (len_q_r == 8'(line_len_r));
          out_mode_nxt  = mode_on;
          if (len_q_r == 8'(line_len_r)) begin
            seen_a_nxt   = 1'b0;
            seen_t_nxt   = 1'b0;
            line_len_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            pos_nxt   = LLW'(len_q_r);
            state_nxt = ST_ARD;
          end
        end
      end

      ST_ARD: begin
        state_nxt = ST_AEMIT;
      end

      // Send the rest of the line as argument bytes
      ST_AEMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = atcm_pkg::KIND_ARG_BYTE;
          out_value_nxt = line_q_r;
          out_last_nxt  = (pos_r + LLW'(1) == line_len_r);
          out_mode_nxt  = mode_on;
          if (pos_r + LLW'(1) == line_len_r) begin
            seen_a_nxt   = 1'b0;
            seen_t_nxt   = 1'b0;
            line_len_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            pos_nxt   = pos_r + LLW'(1);
            state_nxt = ST_ARD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      esc_r       <= atcm_pkg::ESC_NONE;
      seen_a_r    <= 1'b0;
      seen_t_r    <= 1'b0;
      line_len_r  <= '0;
      cmd_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      seen_a_r    <= seen_a_nxt;
      seen_t_r    <= seen_t_nxt;
      line_len_r  <= line_len_nxt;
      cmd_count_r <= cmd_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    entry_r     <= entry_nxt;
    base_r      <= base_nxt;
    pos_r       <= pos_nxt;
    ok_cnt_r    <= ok_cnt_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_mode_r  <= out_mode_nxt;
  end

  // Line buffer: written at the fill point, read at the walk position
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_len_r[LW-1:0]] <= in_data;
    end
    line_q_r <= line_mem[pos_r[LW-1:0]];
  end

  // Command characters, one row of LINE_DEPTH per entry
  always_ff @(posedge clk) begin
    if (chars_we) begin
      chars_mem[chars_waddr] <= in_data;
    end
    char_q_r <= chars_mem[chars_raddr];
  end

  // Command lengths
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[in_table_index[EW-1:0]] <= in_data;
    end
    len_q_r <= len_mem[entry_r[EW-1:0]];
  end

endmodule

`default_nettype wire

// File: dv/atcm_line_checker.sv
// Checker for the AT command line matcher: predicts the result stream from the
// accepted input transactions and compares it with the out_ channel.
// Depends on atcm_pkg for codes, character constants and default sizes.
`timescale 1ns / 1ps

module atcm_line_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data,
  input  logic [4:0] in_table_index,
  input  logic [5:0] in_char_position,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_value,
  input  logic       out_last,
  input  logic       out_command_mode,
  input  logic       cfg_write_en,
  input  logic [5:0] cfg_write_data,
  input  logic       end_check,
  output int         fail_count,
  output int         pending_count
);
  import atcm_pkg::*;

  localparam int LINE_MAX   = LINE_DEPTH_DEF;
  localparam int ENTRIES    = TABLE_ENTRIES_DEF;
  localparam int PRINT_CAP  = 30;

  typedef struct {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
    logic       mode;
  } line_result_t;

  // Predicted state of the matcher
  esc_t       esc = ESC_NONE;
  bit         got_a;
  bit         got_t;
  logic [7:0] line_buf [LINE_MAX];
  int         line_len;
  logic [7:0] table_text [ENTRIES][LINE_MAX];
  logic [7:0] table_len [ENTRIES];
  logic [5:0] search_count;

  line_result_t expected_q [$];
  int           mismatches = 0;
  bit           end_seen = 1'b0;

  assign fail_count = mismatches;

  initial begin
    foreach (table_len[e]) table_len[e] = '0;
    foreach (table_text[e, p]) table_text[e][p] = '0;
    foreach (line_buf[p]) line_buf[p] = '0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic push_result(input kind_t k, input logic [7:0] v);
    line_result_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    r.mode  = (esc == ESC_CMD_MODE);
    expected_q.push_back(r);
  endtask

  // An entry matches when it is non-empty, fits in the line and opens it
  function automatic bit entry_hits(input int e);
    int p;
    if (table_len[e] == 0 || table_len[e] > line_len) return 1'b0;
    for (p = 0; p < table_len[e]; p++)
      if (table_text[e][p] != line_buf[p]) return 1'b0;
    return 1'b1;
  endfunction

  // Line end: null command, or first matching entry plus the argument bytes
  task automatic close_line();
    int lim;
    int hit;
    int e;
    int p;
    lim = (search_count > ENTRIES) ? ENTRIES : int'(search_count);
    if (line_len == 0) begin
      push_result(KIND_EMPTY_LINE, NULL_CMD);
    end else begin
      hit = -1;
      for (e = 0; e < lim && hit < 0; e++)
        if (entry_hits(e)) hit = e;
      if (hit >= 0) begin
        push_result(KIND_MATCH, 8'(hit));
        for (p = table_len[hit]; p < line_len; p++)
          push_result(KIND_ARG_BYTE, line_buf[p]);
      end
    end
    got_a    = 1'b0;
    got_t    = 1'b0;
    line_len = 0;
  endtask

  task automatic predict_transaction(input cmd_t c, input logic [7:0] d,
                                     input logic [4:0] ti, input logic [5:0] cp);
    int queued;
    queued = expected_q.size();
    case (c)
      CMD_LOAD_CHAR: begin
        if (cp < LINE_MAX) table_text[ti][cp] = d;
      end
      CMD_LOAD_LEN: begin
        table_len[ti] = d;
      end
      CMD_EXIT: begin
        esc = ESC_NONE;
      end
      CMD_RX_BYTE: begin
        if (esc != ESC_CMD_MODE) begin
          // count pluses; anything else drops the byte and restarts the count
          if (d != CH_PLUS) begin
            esc = ESC_NONE;
          end else begin
            esc = esc.next();
            if (esc == ESC_CMD_MODE) begin
              push_result(KIND_TX_BYTE, CH_O);
              push_result(KIND_TX_BYTE, CH_K);
              push_result(KIND_TX_BYTE, CH_LF);
              push_result(KIND_TX_BYTE, CH_CR);
            end
          end
        end else if (!got_a) begin
          if (d == CH_A) got_a = 1'b1;
        end else if (!got_t) begin
          if (d == CH_T) begin
            got_t    = 1'b1;
            line_len = 0;
          end
        end else if (d == CH_LF || d == CH_CR) begin
          close_line();
        end else if (line_len < LINE_MAX) begin
          line_buf[line_len] = d;
          line_len++;
        end
      end
    endcase
    // flag the final result of this transaction
    if (expected_q.size() > queued) expected_q[expected_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    line_result_t oldest;
    if (!rst_n) begin
      esc          = ESC_NONE;
      got_a        = 1'b0;
      got_t        = 1'b0;
      line_len     = 0;
      search_count = '0;
      expected_q.delete();
    end else begin
      if (cfg_write_en) search_count = cfg_write_data;

      // compare each accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %02h last %0b",
                                    out_kind, out_value, out_last));
        end else begin
          oldest = expected_q.pop_front();
          if (out_kind !== oldest.kind || out_value !== oldest.value ||
              out_last !== oldest.last || out_command_mode !== oldest.mode) begin
            report_mismatch($sformatf(
              "got kind %0d value %02h last %0b mode %0b, want %0d %02h %0b %0b",
              out_kind, out_value, out_last, out_command_mode,
              oldest.kind, oldest.value, oldest.last, oldest.mode));
          end
        end
      end

      if (in_valid && in_ready)
        predict_transaction(cmd_t'(in_cmd), in_data, in_table_index, in_char_position);

      // anything still waiting at the end never arrived
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        while (expected_q.size() > 0) begin
          oldest = expected_q.pop_front();
          report_mismatch($sformatf("missing result kind %0d value %02h",
                                    oldest.kind, oldest.value));
        end
      end
    end
    pending_count <= expected_q.size();
  end

endmodule

// File: dv/tb_top.sv
// Top of the AT command line matcher testbench: clock, reset, stimulus and
// verdict. Depends on atcm_pkg, the matcher RTL and atcm_line_checker.
`timescale 1ns / 1ps

module tb_top;
  import atcm_pkg::*;

  localparam int LINE_MAX      = LINE_DEPTH_DEF;
  localparam int ENTRIES       = TABLE_ENTRIES_DEF;
  localparam int SETTLE_CYCLES = 3000;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 15;
  localparam int PHASES        = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  cmd_t       in_cmd = CMD_RX_BYTE;
  logic [7:0] in_data = '0;
  logic [4:0] in_table_index = '0;
  logic [5:0] in_char_position = '0;
  logic       out_ready = 1'b0;
  logic       cfg_write_en = 1'b0;
  logic [5:0] cfg_write_data = '0;
  logic       end_check = 1'b0;

  wire        in_ready;
  wire        out_valid;
  wire [1:0]  out_kind;
  wire [7:0]  out_value;
  wire        out_last;
  wire        out_command_mode;
  int         chk_fails;
  int         chk_pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int items_sent = 0;

  // Copy of the command table as loaded, used to build matching lines
  logic [7:0] text_mirror [ENTRIES][LINE_MAX];
  bit         written [ENTRIES][LINE_MAX];
  logic [7:0] len_mirror [ENTRIES];
  bit         in_cmd_mode = 1'b0;

  logic [7:0] alphabet [8] = '{"D", "H", "S", "Z", "0", "1", "&", "="};

  at_command_line_matcher uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_data          (in_data),
    .in_table_index   (in_table_index),
    .in_char_position (in_char_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_last         (out_last),
    .out_command_mode (out_command_mode),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data)
  );

  atcm_line_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_data          (in_data),
    .in_table_index   (in_table_index),
    .in_char_position (in_char_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_last         (out_last),
    .out_command_mode (out_command_mode),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .end_check        (end_check),
    .fail_count       (chk_fails),
    .pending_count    (chk_pending)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_item(input cmd_t c, input logic [7:0] d,
                           input logic [4:0] ti, input logic [5:0] cp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= c;
    in_data          <= d;
    in_table_index   <= ti;
    in_char_position <= cp;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] d);
    send_item(CMD_RX_BYTE, d, 5'($urandom), 6'($urandom));
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_exit();
    send_item(CMD_EXIT, 8'($urandom), 5'($urandom), 6'($urandom));
    in_cmd_mode = 1'b0;
  endtask

  task automatic load_char(input logic [4:0] e, input logic [5:0] pos, input logic [7:0] d);
    send_item(CMD_LOAD_CHAR, d, e, pos);
    if (pos < LINE_MAX) begin
      text_mirror[e][pos] = d;
      written[e][pos]     = 1'b1;
    end
  endtask

  task automatic load_len(input logic [4:0] e, input logic [7:0] n);
    send_item(CMD_LOAD_LEN, n, e, 6'($urandom));
    len_mirror[e] = n;
  endtask

  // Any byte that does not end a line
  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // Fill every character an entry can compare, then its length
  task automatic load_entry(input logic [4:0] e, input logic [7:0] n);
    int p;
    if (n <= LINE_MAX) begin
      for (p = 0; p < n; p++)
        load_char(e, 6'(p), (p == 0 || $urandom_range(4) != 0) ?
                  alphabet[$urandom_range(7)] : line_byte());
    end
    load_len(e, n);
  endtask

  // AT, optional stray byte, entry text, argument bytes and a line end
  task automatic send_line(input int e, input int extra);
    logic [7:0] stray;
    int p;
    send_byte(CH_A);
    if ($urandom_range(3) == 0) begin
      do stray = 8'($urandom); while (stray == CH_T);
      send_byte(stray);
    end
    send_byte(CH_T);
    if (e >= 0)
      for (p = 0; p < len_mirror[e] && p < LINE_MAX; p++) send_byte(text_mirror[e][p]);
    for (p = 0; p < extra; p++) send_byte(line_byte());
    send_byte($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  task automatic write_count(input logic [5:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Drop valid, wait for every predicted result, then let the search finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random sequence: mostly escapes and command lines, some table loads and noise
  task automatic random_sequence();
    int pick;
    int e;
    int tries;
    int r;
    logic [7:0] n;
    int p;
    bit ok;
    pick = $urandom_range(99);
    if (!in_cmd_mode || pick < 10) begin
      send_exit();
      if ($urandom_range(2) == 0) begin
        // broken escape: a non-plus byte restarts the count
        send_text("++");
        do n = 8'($urandom); while (n == CH_PLUS);
        send_byte(n);
        if ($urandom_range(1)) send_byte(CH_PLUS);
      end else begin
        send_text("+++");
        in_cmd_mode = 1'b1;
      end
    end else if (pick < 62) begin
      r = $urandom_range(99);
      if (r < 15) begin
        send_line(-1, 0);
      end else if (r < 35) begin
        send_line(-1, $urandom_range(1, 6));
      end else begin
        e = -1;
        for (tries = 0; tries < 12 && e < 0; tries++) begin
          p = $urandom_range(ENTRIES - 1);
          if (len_mirror[p] >= 1 && len_mirror[p] <= 8) e = p;
        end
        send_line(e, $urandom_range(0, 5));
      end
    end else if (pick < 77) begin
      e = $urandom_range(2, ENTRIES - 1);
      r = $urandom_range(99);
      if (r < 60) load_entry(5'(e), 8'($urandom_range(1, 4)));
      else if (r < 70) load_len(5'(e), 8'd0);
      else if (r < 85) load_len(5'(e), 8'($urandom_range(LINE_MAX + 1, 255)));
      else begin
        load_char(5'(e), 6'($urandom), 8'($urandom));
        load_char(5'(e), 6'($urandom_range(LINE_MAX, 63)), 8'($urandom));
      end
    end else begin
      r = $urandom_range(99);
      if (r < 40) begin
        send_byte(8'($urandom));
      end else if (r < 55) begin
        send_exit();
      end else if (r < 80) begin
        load_char(5'($urandom), 6'($urandom), 8'($urandom));
      end else begin
        // a length may only cover characters already loaded
        e  = $urandom_range(ENTRIES - 1);
        n  = 8'($urandom);
        ok = 1'b1;
        if (n >= 1 && n <= LINE_MAX)
          for (p = 0; p < n; p++) ok &= written[e][p];
        load_len(5'(e), ok ? n : 8'd0);
      end
    end
  endtask

  initial begin : stimulus
    logic [5:0] plan [PHASES];
    int ph;
    int first;
    int e;
    foreach (written[i, j]) written[i][j] = 1'b0;
    foreach (text_mirror[i, j]) text_mirror[i][j] = '0;
    foreach (len_mirror[i]) len_mirror[i] = '0;
    plan = '{6'd63, 6'd0, 6'd1, 6'd32, 6'($urandom_range(2, 31)), 6'($urandom_range(63))};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_count(6'd32);

    // Command table: short entries, one full-depth entry, empty and over-long lengths
    for (e = 2; e < ENTRIES; e++) begin
      case (e)
        28:      load_entry(5'(e), 8'(LINE_MAX + 1));
        29:      load_entry(5'(e), 8'd0);
        30:      load_entry(5'(e), 8'(LINE_MAX));
        31:      load_entry(5'(e), 8'd255);
        default: load_entry(5'(e), 8'($urandom_range(1, 4)));
      endcase
    end
    load_char(5'd0, 6'd0, "S");
    load_char(5'd0, 6'd1, "0");
    load_len(5'd0, 8'd2);
    load_char(5'd1, 6'd0, "S");
    load_len(5'd1, 8'd1);

    // Directed: escape with a restart, ignored loads, A and T apart, null line,
    // entry longer than the line, match with arguments, no match, exit
    send_text("++q+++");
    in_cmd_mode = 1'b1;
    send_item(CMD_LOAD_CHAR, 8'hA5, 5'd3, 6'(LINE_MAX));
    send_item(CMD_LOAD_CHAR, 8'h5A, 5'd31, 6'd63);
    send_text("AzT\r");
    send_text("ATS\r");
    send_text("ATS0=5\n");
    send_text("AT#\r");
    send_exit();

    // Random phases, each with its entry count from the plan and one of four idle patterns
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_count(plan[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      first = items_sent;
      if (!in_cmd_mode) begin
        send_exit();
        send_text("+++");
        in_cmd_mode = 1'b1;
      end
      // overflowing line, and a full line behind a one-character entry
      if (ph == 2) send_line(30, 4);
      if (ph == 3) send_line(1, LINE_MAX - 1);
      while (items_sent - first < PHASE_ITEMS) random_sequence();
    end

    settle();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (chk_fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
